### src/vdf_pkg.sv
// Shared types and constants for the voxel first-point filter.
// No dependencies.
`default_nettype none
package vdf_pkg;

  localparam int unsigned SEEN_CAPACITY_DEF = 4096;
  localparam int unsigned AXIS_KEY_BITS_DEF = 21;
  localparam int unsigned PROD_FRAC_BITS    = 26;
  localparam int unsigned KEY_W             = 63;
  localparam int unsigned COUNT_W           = 13;
  localparam logic [12:0] COUNT_MAX         = 13'd8191;
  localparam logic [31:0] INV_VOXEL_RESET   = 32'd131072;

  localparam logic [1:0] ST_KEPT_NEW  = 2'd0;
  localparam logic [1:0] ST_NONFINITE = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_KEPT_FULL = 2'd3;

  typedef struct packed {
    logic              first_in_scan;
    logic              coords_finite;
    logic [KEY_W-1:0]  key;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]       intensity;
  } vdf_item_t;

endpackage
`default_nettype wire

### src/vdf_front.sv
// Front end: accepts points, scales the coordinates and forms voxel keys.
// Depends on vdf_pkg.
`default_nettype none
module vdf_front
  import vdf_pkg::*;
#(
  parameter int unsigned AXIS_KEY_BITS = AXIS_KEY_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_first_in_scan,
  input  wire logic               in_coords_finite,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic [15:0]        in_intensity,
  output logic                    push,
  output vdf_item_t               push_item,
  input  wire logic               fifo_full
);

  logic [31:0]        inv_r;
  logic               s1_valid_r, s2_valid_r;
  vdf_item_t          s1_r, s2_r;
  logic signed [63:0] px_r, py_r, pz_r;
  logic               s1_go, s2_ok;
  logic [3*AXIS_KEY_BITS-1:0] key_packed;

  assign push     = s2_valid_r && !fifo_full;
  assign s2_ok    = !s2_valid_r || !fifo_full;
  assign s1_go    = s1_valid_r && s2_ok;
  assign in_stall = s1_valid_r && !s2_ok;

  assign key_packed = {px_r[PROD_FRAC_BITS +: AXIS_KEY_BITS],
                       py_r[PROD_FRAC_BITS +: AXIS_KEY_BITS],
                       pz_r[PROD_FRAC_BITS +: AXIS_KEY_BITS]};

  always_comb begin
    push_item     = s2_r;
    push_item.key = s2_r.coords_finite ? KEY_W'(key_packed) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r      <= INV_VOXEL_RESET;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_we) inv_r <= cfg_wdata;
      if (!in_stall) s1_valid_r <= in_valid;
      if (s2_ok) s2_valid_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_r.first_in_scan <= in_first_in_scan;
      s1_r.coords_finite <= in_coords_finite;
      s1_r.key           <= '0;
      s1_r.pos_x         <= in_pos_x;
      s1_r.pos_y         <= in_pos_y;
      s1_r.pos_z         <= in_pos_z;
      s1_r.intensity     <= in_intensity;
    end
    if (s1_go) begin
      s2_r <= s1_r;
      px_r <= 64'(s1_r.pos_x) * 64'($signed({1'b0, inv_r}));
      py_r <= 64'(s1_r.pos_y) * 64'($signed({1'b0, inv_r}));
      pz_r <= 64'(s1_r.pos_z) * 64'($signed({1'b0, inv_r}));
    end
  end

endmodule
`default_nettype wire

### src/vdf_fifo.sv
// Two-entry queue between the front end and the set lookup.
// Depends on vdf_pkg.
`default_nettype none
module vdf_fifo
  import vdf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  vdf_item_t      push_item,
  output logic           full,
  input  wire logic      pop,
  output vdf_item_t      pop_item,
  output logic           empty
);

  vdf_item_t  mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_item = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

endmodule
`default_nettype wire

### src/vdf_back.sv
// Back end: searches the seen-key memory, records new keys, drives results.
// Depends on vdf_pkg.
`default_nettype none
module vdf_back
  import vdf_pkg::*;
#(
  parameter int unsigned SEEN_CAPACITY = SEEN_CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               empty,
  input  vdf_item_t               pop_item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [KEY_W-1:0]        out_vox_key,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [15:0]             out_intensity,
  output logic [COUNT_W-1:0]      out_voxels_in_scan
);

  localparam int unsigned AW = $clog2(SEEN_CAPACITY);
  localparam int unsigned CW = $clog2(SEEN_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(SEEN_CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [KEY_W-1:0] mem [SEEN_CAPACITY];
  logic [KEY_W-1:0] rdata_r;

  logic [1:0]    st_r, st_nxt;
  logic [CW-1:0] count_r, count_nxt, count_eff;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    status_r, status_nxt;
  vdf_item_t     cur_r;
  vdf_item_t     item;
  logic          we;
  logic          out_valid_r;
  logic [1:0]    o_status_r;
  logic [KEY_W-1:0] o_key_r;
  logic signed [31:0] o_x_r, o_y_r, o_z_r;
  logic [15:0]   o_int_r;
  logic [COUNT_W-1:0] o_cnt_r, vis;
  logic          load_out;

  assign item      = (st_r == S_IDLE) ? pop_item : cur_r;
  assign count_eff = (st_r == S_IDLE && pop_item.first_in_scan) ? '0 : count_r;
  assign load_out  = (st_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    if (32'(count_r) > 32'(COUNT_MAX)) vis = COUNT_MAX;
    else vis = COUNT_W'(count_r);
  end

  always_comb begin
    st_nxt     = st_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    pop        = 1'b0;
    we         = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          count_nxt = count_eff;
          if (!pop_item.coords_finite) begin
            status_nxt = ST_NONFINITE;
            st_nxt     = S_OUT;
          end else if (count_eff == '0) begin
            we         = 1'b1;
            count_nxt  = count_eff + CW'(1);
            status_nxt = ST_KEPT_NEW;
            st_nxt     = S_OUT;
          end else begin
            idx_nxt = '0;
            st_nxt  = S_READ;
          end
        end
      end
      S_READ: st_nxt = S_CMP;
      S_CMP: begin
        if (rdata_r == cur_r.key) begin
          status_nxt = ST_DUPLICATE;
          st_nxt     = S_OUT;
        end else if (idx_r + CW'(1) == count_r) begin
          if (count_r < CAP) begin
            we         = 1'b1;
            count_nxt  = count_r + CW'(1);
            status_nxt = ST_KEPT_NEW;
          end else begin
            status_nxt = ST_KEPT_FULL;
          end
          st_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + CW'(1);
          st_nxt  = S_READ;
        end
      end
      S_OUT: if (load_out) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    if (pop) cur_r <= pop_item;
    if (we) mem[count_eff[AW-1:0]] <= item.key;
    if (st_r == S_READ) rdata_r <= mem[idx_r[AW-1:0]];
    if (load_out) begin
      o_status_r <= status_r;
      o_key_r    <= cur_r.key;
      o_x_r      <= cur_r.pos_x;
      o_y_r      <= cur_r.pos_y;
      o_z_r      <= cur_r.pos_z;
      o_int_r    <= cur_r.intensity;
      o_cnt_r    <= vis;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_vox_key        = o_key_r;
  assign out_x              = o_x_r;
  assign out_y              = o_y_r;
  assign out_z              = o_z_r;
  assign out_intensity      = o_int_r;
  assign out_voxels_in_scan = o_cnt_r;

endmodule
`default_nettype wire

### src/voxel_dedup_filter_unit.sv
// Top level of the voxel first-point filter: front end, queue, set lookup.
// Depends on vdf_pkg, vdf_front, vdf_fifo and vdf_back.
//
// Usage: one point per input transfer (in_valid/in_stall), one result per
// point on the output channel (out_valid/out_stall). cfg_we writes the
// Q16.16 inverse voxel size; write it only while the block is idle.
// The front end registers the point, multiplies its coordinates and then
// queues the point with its voxel key. The lookup reads the seen-key
// memory one entry at a time (read, then compare), in insertion order,
// through its single read port, until the first match or the last of the
// keys recorded in the scan so far. A non-finite point or the first point
// of a scan skips the search. Reset restores the default inverse voxel
// size (2.0 per metre) and empties the set; no clearing pass is needed,
// the fill count marks valid entries. A stalled result holds in the
// output register; the lookup, the queue and the two front stages let
// the front end accept five more points before in_stall rises.
`default_nettype none
module voxel_dedup_filter_unit
  import vdf_pkg::*;
#(
  parameter int unsigned SEEN_CAPACITY = SEEN_CAPACITY_DEF,
  parameter int unsigned AXIS_KEY_BITS = AXIS_KEY_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_first_in_scan,
  input  wire logic               in_coords_finite,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic [15:0]        in_intensity,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [KEY_W-1:0]        out_vox_key,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [15:0]             out_intensity,
  output logic [COUNT_W-1:0]      out_voxels_in_scan
);

  logic      push, pop, full, empty;
  vdf_item_t push_item, pop_item;

  vdf_front #(.AXIS_KEY_BITS(AXIS_KEY_BITS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .in_first_in_scan, .in_coords_finite, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_intensity, .push, .push_item, .fifo_full(full)
  );

  vdf_fifo u_fifo (
    .clk, .rst_n, .push, .push_item, .full, .pop, .pop_item, .empty
  );

  vdf_back #(.SEEN_CAPACITY(SEEN_CAPACITY)) u_back (
    .clk, .rst_n, .empty, .pop_item, .pop, .out_valid, .out_stall,
    .out_status, .out_vox_key, .out_x, .out_y, .out_z, .out_intensity,
    .out_voxels_in_scan
  );

endmodule
`default_nettype wire

### src/vdf_checker.sv
// Port-level checks for the voxel filter, bound to the top level.
// Depends on vdf_pkg and voxel_dedup_filter_unit.
`default_nettype none
module vdf_checker
  import vdf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic [KEY_W-1:0]   out_vox_key,
  input wire logic [COUNT_W-1:0] out_voxels_in_scan
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vox_key))
    else $error("stalled result changed");

  a_nonfinite_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONFINITE |-> out_vox_key == '0)
    else $error("non-finite point carries a key");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_KEPT_NEW || out_status == ST_DUPLICATE)
    |-> out_voxels_in_scan != '0)
    else $error("recorded or matched key with empty set");

endmodule

bind voxel_dedup_filter_unit vdf_checker u_vdf_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_status, .out_vox_key,
  .out_voxels_in_scan
);
`default_nettype wire
